FILE: src/jbf_pkg.sv
// ----------------------------------------------------------------------------
// jbf_pkg
// Shared constants, codes and controller/datapath interface types for the
// joint bilateral filter core.
// ----------------------------------------------------------------------------
package jbf_pkg;

    localparam int MAX_LINE    = 1024;
    localparam int MAX_RADIUS  = 4;
    localparam int WEIGHT_BITS = 16;

    localparam int STORE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_LINE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PIX_W       = 8;
    localparam int WORD_W      = 4 * PIX_W;
    localparam int GUIDE_DEPTH = 256;
    localparam int GIDX_W      = 8;
    localparam int TVAL_W      = 16;

    localparam int LEN_W       = 11;
    localparam int CNT_W       = 16;
    localparam int RAD_W       = 3;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    localparam int WID_W       = $clog2(MAX_LINE + 1);
    localparam int RADC_W      = $clog2(MAX_RADIUS + 1);
    localparam int K_W         = RADC_W + 1;
    localparam int DLY_W       = $clog2(MAX_RADIUS * MAX_LINE + MAX_RADIUS + 1);
    localparam int POS_W       = $clog2(MAX_LINE) + CNT_W;
    localparam int OX_W        = $clog2(MAX_LINE);
    localparam int PROD_W      = 2 * WEIGHT_BITS;
    localparam int WSUM_W      = WEIGHT_BITS + $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1));
    localparam int PSUM_W      = WSUM_W + PIX_W;
    localparam int QCNT_W      = $clog2(PIX_W);

    localparam logic [1:0] CMD_PIXEL  = 2'd0;
    localparam logic [1:0] CMD_DRAIN  = 2'd1;
    localparam logic [1:0] CMD_LOAD_G = 2'd2;
    localparam logic [1:0] CMD_LOAD_S = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_GUIDE = 2'd3;

    typedef struct packed {
        logic init;
        logic cen;
        logic tap_issue;
        logic tap_skip;
        logic t1;
        logic t2;
        logic t3;
        logic t4;
        logic t5;
        logic t6;
        logic t7;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic run;
        logic emit;
        logic tap_in;
        logic tap_last;
        logic color;
        logic div_fast;
        logic div_last;
        logic out_free;
        logic last_out;
    } t_stat;

endpackage

FILE: src/jbf_ram.sv
// ----------------------------------------------------------------------------
// jbf_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module jbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/jbf_ctrl.sv
// ----------------------------------------------------------------------------
// jbf_ctrl
// Sequencer: walks each output pixel through centre fetch, window taps,
// division and output load.
// ----------------------------------------------------------------------------
module jbf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  jbf_pkg::t_stat i_stat,
    output jbf_pkg::t_cmd  o_cmd,
    output logic           o_in_ready
);
    import jbf_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_CEN   = 4'd2;
    localparam logic [3:0] S_TAP   = 4'd3;
    localparam logic [3:0] S_T1    = 4'd4;
    localparam logic [3:0] S_T2    = 4'd5;
    localparam logic [3:0] S_T3    = 4'd6;
    localparam logic [3:0] S_T4    = 4'd7;
    localparam logic [3:0] S_T5    = 4'd8;
    localparam logic [3:0] S_T6    = 4'd9;
    localparam logic [3:0] S_T7    = 4'd10;
    localparam logic [3:0] S_DIV0  = 4'd11;
    localparam logic [3:0] S_DIV   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_stat.run) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.emit) begin
                    cmd.init = 1'b1;
                    n_state  = S_CEN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CEN: begin
                cmd.cen = 1'b1;
                n_state = S_TAP;
            end
            S_TAP: begin
                if (i_stat.tap_in) begin
                    cmd.tap_issue = 1'b1;
                    n_state       = S_T1;
                end else begin
                    cmd.tap_skip = 1'b1;
                    n_state      = i_stat.tap_last ? S_DIV0 : S_TAP;
                end
            end
            S_T1: begin
                cmd.t1  = 1'b1;
                n_state = S_T2;
            end
            S_T2: begin
                cmd.t2  = 1'b1;
                n_state = i_stat.color ? S_T3 : S_T5;
            end
            S_T3: begin
                cmd.t3  = 1'b1;
                n_state = S_T4;
            end
            S_T4: begin
                cmd.t4  = 1'b1;
                n_state = S_T5;
            end
            S_T5: begin
                cmd.t5  = 1'b1;
                n_state = S_T6;
            end
            S_T6: begin
                cmd.t6  = 1'b1;
                n_state = S_T7;
            end
            S_T7: begin
                cmd.t7  = 1'b1;
                n_state = i_stat.tap_last ? S_DIV0 : S_TAP;
            end
            S_DIV0: begin
                cmd.div_init = 1'b1;
                n_state      = i_stat.div_fast ? S_OUT : S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                n_state      = i_stat.div_last ? S_OUT : S_DIV;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);
endmodule

FILE: src/jbf_datapath.sv
// ----------------------------------------------------------------------------
// jbf_datapath
// Configuration, frame positions, line store, weight tables, shared
// multiplier, accumulators, restoring divider and output register.
// ----------------------------------------------------------------------------
module jbf_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [1:0]                      i_cmd,
    input  logic [jbf_pkg::PIX_W-1:0]       i_pixel,
    input  logic [jbf_pkg::PIX_W-1:0]       i_guide_a,
    input  logic [jbf_pkg::PIX_W-1:0]       i_guide_b,
    input  logic [jbf_pkg::PIX_W-1:0]       i_guide_c,
    input  logic [jbf_pkg::GIDX_W-1:0]      i_table_index,
    input  logic [jbf_pkg::TVAL_W-1:0]      i_table_value,
    input  logic                            i_cfg_we,
    input  logic [jbf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [jbf_pkg::CFG_W-1:0]       i_cfg_data,
    input  jbf_pkg::t_cmd                   i_ctl,
    output jbf_pkg::t_stat                  o_stat,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [jbf_pkg::PIX_W-1:0]       o_out_pixel,
    output logic                            o_frame_end
);
    import jbf_pkg::*;

    localparam int XS_W = WID_W + 2;
    localparam int YS_W = CNT_W + 2;
    localparam int WB   = WEIGHT_BITS;

    function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] res;
        begin
            res = (a == ADDR_W'(STORE_DEPTH - 1)) ? '0 : a + 1'b1;
            return res;
        end
    endfunction

    function automatic logic [GIDX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] d;
        begin
            d = (a > b) ? a - b : b - a;
            return GIDX_W'(d);
        end
    endfunction

    logic [LEN_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic              r_color;
    logic [WID_W-1:0]  w_eff;
    logic [CNT_W-1:0]  h_eff;
    logic [RADC_W-1:0] r_eff;
    logic [WID_W+CNT_W-1:0]  tot_full;
    logic [RADC_W+WID_W:0]   dly_full;
    logic [POS_W-1:0]  r_total;
    logic [DLY_W-1:0]  r_delay;

    logic [POS_W-1:0]  r_in;
    logic [POS_W-1:0]  r_out;
    logic [ADDR_W-1:0] r_iaddr;
    logic [ADDR_W-1:0] r_oaddr;
    logic [OX_W-1:0]   r_ox;
    logic [CNT_W-1:0]  r_oy;

    logic [K_W-1:0]    r_k;
    logic [K_W-1:0]    r_l;
    logic [K_W-1:0]    two_r;
    logic [K_W-1:0]    r_ext;
    logic [ADDR_W-1:0] r_rowaddr;
    logic [ADDR_W-1:0] r_taddr;
    logic [ADDR_W:0]   start_sum;
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W:0]   row_sum;
    logic [ADDR_W-1:0] row_next;
    logic [K_W-1:0]    ady_full;
    logic [K_W-1:0]    adx_full;
    logic signed [YS_W-1:0] ty;
    logic signed [XS_W-1:0] tx;
    logic              y_in;
    logic              x_in;
    logic              advance;
    logic              last_out;
    logic [POS_W:0]    out_inc;
    logic              frame_done;

    logic [WB-1:0]     r_sp [0:MAX_RADIUS];
    logic [RADC_W-1:0] sp_idx;
    logic [WB-1:0]     sp_val;

    logic              line_we;
    logic [ADDR_W-1:0] line_raddr;
    logic [WORD_W-1:0] line_rdata;
    logic              g_we;
    logic [GIDX_W-1:0] g_raddr;
    logic [WB-1:0]     g_rdata;

    logic [WORD_W-1:0] r_cen;
    logic [WORD_W-1:0] r_tap;
    logic [WB-1:0]     r_sy;
    logic [WB-1:0]     r_ws;
    logic [WB-1:0]     r_wg;
    logic [WB-1:0]     r_w;
    logic [WB+PIX_W-1:0] r_prod;
    logic [WSUM_W-1:0] r_wsum;
    logic [PSUM_W-1:0] r_psum;
    logic [WB-1:0]     mul_a;
    logic [WB-1:0]     mul_b;
    logic [PROD_W-1:0] mul_p;

    logic [PSUM_W-1:0] r_rem;
    logic [PSUM_W-1:0] r_div;
    logic [PIX_W-1:0]  r_q;
    logic [QCNT_W-1:0] r_qi;
    logic              sat;
    logic              emit;

    logic              r_ov;
    logic [PIX_W-1:0]  r_opix;
    logic              r_oend;

    // effective configuration
    always_comb begin
        if (r_len == '0) begin
            w_eff = WID_W'(1);
        end else if (r_len > LEN_W'(MAX_LINE)) begin
            w_eff = WID_W'(MAX_LINE);
        end else begin
            w_eff = WID_W'(r_len);
        end
        h_eff = (r_cnt == '0) ? CNT_W'(1) : r_cnt;
        r_eff = (r_rad > RAD_W'(MAX_RADIUS)) ? RADC_W'(MAX_RADIUS) : RADC_W'(r_rad);
    end

    assign tot_full = (WID_W+CNT_W)'(w_eff) * (WID_W+CNT_W)'(h_eff);
    assign dly_full = (RADC_W+WID_W+1)'(r_eff) * (RADC_W+WID_W+1)'(w_eff)
                    + (RADC_W+WID_W+1)'(r_eff);

    always_ff @(posedge i_clk) begin
        r_total <= POS_W'(tot_full);
        r_delay <= DLY_W'(dly_full);
    end

    // window walk
    assign two_r = {r_eff, 1'b0};
    assign r_ext = K_W'(r_eff);
    assign ady_full = (r_k >= r_ext) ? r_k - r_ext : r_ext - r_k;
    assign adx_full = (r_l >= r_ext) ? r_l - r_ext : r_ext - r_l;
    assign ty = $signed(YS_W'(r_oy)) + $signed(YS_W'(r_k)) - $signed(YS_W'(r_eff));
    assign tx = $signed(XS_W'(r_ox)) + $signed(XS_W'(r_l)) - $signed(XS_W'(r_eff));
    assign y_in = (ty >= 0) && (ty < $signed(YS_W'(h_eff)));
    assign x_in = (tx >= 0) && (tx < $signed(XS_W'(w_eff)));

    assign start_sum  = {1'b0, r_oaddr} + (ADDR_W+1)'(STORE_DEPTH) - (ADDR_W+1)'(r_delay);
    assign start_addr = (start_sum >= (ADDR_W+1)'(STORE_DEPTH))
                      ? ADDR_W'(start_sum - (ADDR_W+1)'(STORE_DEPTH))
                      : ADDR_W'(start_sum);
    assign row_sum    = {1'b0, r_rowaddr} + (ADDR_W+1)'(w_eff);
    assign row_next   = (row_sum >= (ADDR_W+1)'(STORE_DEPTH))
                      ? ADDR_W'(row_sum - (ADDR_W+1)'(STORE_DEPTH))
                      : ADDR_W'(row_sum);
    assign advance    = i_ctl.tap_skip | i_ctl.t7;

    assign out_inc    = {1'b0, r_out} + 1'b1;
    assign last_out   = (out_inc == {1'b0, r_total});
    assign frame_done = i_ctl.out_load & last_out;

    assign emit = (r_out < r_total)
               && ((r_in >= r_total)
                   || ({1'b0, r_in} > {1'b0, r_out} + (POS_W+1)'(r_delay)));

    // spatial weights, one read per cycle
    assign sp_idx = i_ctl.tap_issue ? RADC_W'(ady_full) : RADC_W'(adx_full);
    assign sp_val = r_sp[sp_idx];

    always_ff @(posedge i_clk) begin
        if (i_accept && (i_cmd == CMD_LOAD_S) && (i_table_index <= GIDX_W'(MAX_RADIUS))) begin
            r_sp[RADC_W'(i_table_index)] <= WB'(i_table_value);
        end
    end

    // stores
    assign line_we    = i_accept && (i_cmd == CMD_PIXEL) && (r_in < r_total);
    assign line_raddr = i_ctl.init ? r_oaddr : r_taddr;

    jbf_ram #(
        .WIDTH(WORD_W),
        .DEPTH(STORE_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (r_iaddr),
        .i_wdata ({i_guide_c, i_guide_b, i_guide_a, i_pixel}),
        .i_raddr (line_raddr),
        .o_rdata (line_rdata)
    );

    assign g_we = i_accept && (i_cmd == CMD_LOAD_G);

    always_comb begin
        if (i_ctl.t1) begin
            g_raddr = absdiff(line_rdata[2*PIX_W-1:PIX_W], r_cen[2*PIX_W-1:PIX_W]);
        end else if (i_ctl.t2) begin
            g_raddr = absdiff(r_tap[3*PIX_W-1:2*PIX_W], r_cen[3*PIX_W-1:2*PIX_W]);
        end else begin
            g_raddr = absdiff(r_tap[4*PIX_W-1:3*PIX_W], r_cen[4*PIX_W-1:3*PIX_W]);
        end
    end

    jbf_ram #(
        .WIDTH(WB),
        .DEPTH(GUIDE_DEPTH)
    ) u_guide_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (i_table_index),
        .i_wdata (WB'(i_table_value)),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    // shared multiplier
    always_comb begin
        if (i_ctl.t1) begin
            mul_a = r_sy;
            mul_b = sp_val;
        end else if (i_ctl.t3 || i_ctl.t4) begin
            mul_a = r_wg;
            mul_b = g_rdata;
        end else if (i_ctl.t6) begin
            mul_a = r_w;
            mul_b = WB'(r_tap[PIX_W-1:0]);
        end else begin
            mul_a = r_ws;
            mul_b = r_wg;
        end
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign sat   = (r_psum >= {r_wsum, {PIX_W{1'b0}}});

    // tap pipeline, accumulators and divider
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_k       <= '0;
            r_l       <= '0;
            r_rowaddr <= start_addr;
            r_taddr   <= start_addr;
            r_wsum    <= '0;
            r_psum    <= '0;
        end else if (advance) begin
            if (r_l == two_r) begin
                r_l       <= '0;
                r_k       <= r_k + 1'b1;
                r_rowaddr <= row_next;
                r_taddr   <= row_next;
            end else begin
                r_l     <= r_l + 1'b1;
                r_taddr <= addr_inc(r_taddr);
            end
        end
        if (i_ctl.cen) begin
            r_cen <= line_rdata;
        end
        if (i_ctl.tap_issue) begin
            r_sy <= sp_val;
        end
        if (i_ctl.t1) begin
            r_tap <= line_rdata;
            r_ws  <= mul_p[PROD_W-1:WB];
        end
        if (i_ctl.t2) begin
            r_wg <= g_rdata;
        end
        if (i_ctl.t3 || i_ctl.t4) begin
            r_wg <= mul_p[PROD_W-1:WB];
        end
        if (i_ctl.t5) begin
            r_w <= mul_p[PROD_W-1:WB];
        end
        if (i_ctl.t6) begin
            r_prod <= mul_p[WB+PIX_W-1:0];
            r_wsum <= r_wsum + WSUM_W'(r_w);
        end
        if (i_ctl.t7) begin
            r_psum <= r_psum + PSUM_W'(r_prod);
        end
        if (i_ctl.div_init) begin
            r_rem <= r_psum;
            r_div <= {r_wsum, {PIX_W{1'b0}}} >> 1;
            r_qi  <= QCNT_W'(PIX_W - 1);
            if (r_wsum == '0) begin
                r_q <= '0;
            end else if (sat) begin
                r_q <= '1;
            end else begin
                r_q <= '0;
            end
        end else if (i_ctl.div_step) begin
            if (r_rem >= r_div) begin
                r_rem <= r_rem - r_div;
                r_q   <= {r_q[PIX_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[PIX_W-2:0], 1'b0};
            end
            r_div <= r_div >> 1;
            r_qi  <= r_qi - 1'b1;
        end
        if (i_ctl.out_load) begin
            r_opix <= r_q;
            r_oend <= last_out;
        end
    end

    // configuration, positions and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_W'(1024);
            r_cnt   <= CNT_W'(1024);
            r_rad   <= RAD_W'(2);
            r_color <= 1'b0;
            r_in    <= '0;
            r_out   <= '0;
            r_iaddr <= '0;
            r_oaddr <= '0;
            r_ox    <= '0;
            r_oy    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LINE_LENGTH: r_len   <= i_cfg_data[LEN_W-1:0];
                    REG_LINE_COUNT:  r_cnt   <= i_cfg_data[CNT_W-1:0];
                    REG_RADIUS:      r_rad   <= i_cfg_data[RAD_W-1:0];
                    REG_COLOR_GUIDE: r_color <= i_cfg_data[0];
                    default: begin
                        r_color <= r_color;
                    end
                endcase
            end
            if (i_cfg_we || frame_done) begin
                r_in    <= '0;
                r_out   <= '0;
                r_iaddr <= '0;
                r_oaddr <= '0;
                r_ox    <= '0;
                r_oy    <= '0;
            end else begin
                if (line_we) begin
                    r_in    <= r_in + 1'b1;
                    r_iaddr <= addr_inc(r_iaddr);
                end
                if (i_ctl.out_load) begin
                    r_out   <= POS_W'(out_inc);
                    r_oaddr <= addr_inc(r_oaddr);
                    if (WID_W'(r_ox) + 1'b1 == w_eff) begin
                        r_ox <= '0;
                        r_oy <= r_oy + 1'b1;
                    end else begin
                        r_ox <= r_ox + 1'b1;
                    end
                end
            end
            if (i_ctl.out_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_stat.run      = i_accept && ((i_cmd == CMD_PIXEL) || (i_cmd == CMD_DRAIN));
    assign o_stat.emit     = emit;
    assign o_stat.tap_in   = y_in && x_in;
    assign o_stat.tap_last = (r_k == two_r) && (r_l == two_r);
    assign o_stat.color    = r_color;
    assign o_stat.div_fast = (r_wsum == '0) || sat;
    assign o_stat.div_last = (r_qi == '0);
    assign o_stat.out_free = !r_ov || i_out_ready;
    assign o_stat.last_out = last_out;

    assign o_out_valid = r_ov;
    assign o_out_pixel = r_opix;
    assign o_frame_end = r_oend;
endmodule

FILE: src/joint_bilateral_filter_core.sv
// ----------------------------------------------------------------------------
// joint_bilateral_filter_core
// Joint bilateral filter over a raster pixel stream with a guide image,
// window taps walked one at a time through a shared multiplier.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    cmd, pixel, guides, table load
//  output    out        o_out_valid / i_out_ready  out_pixel, frame_end
//  config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
//  Loads are taken in idle and leave the sequencer idle. A pixel or drain
//  word that emits walks the in-frame taps T of the (2R+1)^2 window, each
//  with more steps for a color guide than a mono guide, steps past each
//  skipped tap and then forms the quotient; the single multiplier and the
//  guide table port set this pace. Reset is synchronous; no clearing pass
//  is needed. A stalled output holds the next result in the sequencer,
//  while one result waits in the output register without blocking input.
// ----------------------------------------------------------------------------
module joint_bilateral_filter_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_cmd,
    input  logic [jbf_pkg::PIX_W-1:0]       i_pixel,
    input  logic [jbf_pkg::PIX_W-1:0]       i_guide_a,
    input  logic [jbf_pkg::PIX_W-1:0]       i_guide_b,
    input  logic [jbf_pkg::PIX_W-1:0]       i_guide_c,
    input  logic [jbf_pkg::GIDX_W-1:0]      i_table_index,
    input  logic [jbf_pkg::TVAL_W-1:0]      i_table_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [jbf_pkg::PIX_W-1:0]       o_out_pixel,
    output logic                            o_frame_end,
    input  logic                            i_cfg_we,
    input  logic [jbf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [jbf_pkg::CFG_W-1:0]       i_cfg_data
);
    import jbf_pkg::*;

    t_cmd  s_cmd;
    t_stat s_stat;
    logic  accept;

    assign accept = i_in_valid & o_in_ready;

    jbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd),
        .o_in_ready (o_in_ready)
    );

    jbf_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_cmd         (i_cmd),
        .i_pixel       (i_pixel),
        .i_guide_a     (i_guide_a),
        .i_guide_b     (i_guide_b),
        .i_guide_c     (i_guide_c),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_ctl         (s_cmd),
        .o_stat        (s_stat),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_out_pixel   (o_out_pixel),
        .o_frame_end   (o_frame_end)
    );

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.out_load |-> s_stat.out_free)
        else $error("output register overwritten while full");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.out_load && s_stat.last_out) |=> !s_stat.emit)
        else $error("positions not cleared at frame end");

    a_div_slow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.div_step |-> !s_stat.div_fast)
        else $error("divider stepping on zero or saturated sum");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(s_cmd.t1 || s_cmd.div_step || s_cmd.out_load))
        else $error("input taken while filter busy");
endmodule
